[rtl/rmb_pkg.sv]
// ============================================================================
// rmb_pkg: rotation matrix builder shared types and constants
// Item layouts, Q.30 angle constants and the CORDIC arctangent table.
// ============================================================================
package rmb_pkg;

    localparam int unsigned AtanEntries = 24;

    localparam logic signed [33:0] CordicGain = 34'sd652032874;
    localparam logic signed [33:0] PiQ30      = 34'sd3373259426;
    localparam logic signed [33:0] HalfPiQ30  = 34'sd1686629713;
    localparam logic signed [19:0] OneQ14     = 20'sd16384;

    localparam logic OpEuler = 1'b0;
    localparam logic OpQuat  = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r01;
        logic signed [15:0] r02;
        logic signed [15:0] r10;
        logic signed [15:0] r11;
        logic signed [15:0] r12;
        logic signed [15:0] r20;
        logic signed [15:0] r21;
        logic signed [15:0] r22;
    } t_out_item;

    // atan(2^-i) in Q.30
    function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
        logic signed [33:0] v;
        case (idx)
            5'd0:    v = 34'sd843314856;
            5'd1:    v = 34'sd497837829;
            5'd2:    v = 34'sd262043836;
            5'd3:    v = 34'sd133525158;
            5'd4:    v = 34'sd67021686;
            5'd5:    v = 34'sd33543515;
            5'd6:    v = 34'sd16775850;
            5'd7:    v = 34'sd8388437;
            5'd8:    v = 34'sd4194282;
            5'd9:    v = 34'sd2097149;
            5'd10:   v = 34'sd1048575;
            5'd11:   v = 34'sd524287;
            5'd12:   v = 34'sd262143;
            5'd13:   v = 34'sd131071;
            5'd14:   v = 34'sd65535;
            5'd15:   v = 34'sd32767;
            5'd16:   v = 34'sd16383;
            5'd17:   v = 34'sd8191;
            5'd18:   v = 34'sd4095;
            5'd19:   v = 34'sd2047;
            5'd20:   v = 34'sd1023;
            5'd21:   v = 34'sd511;
            5'd22:   v = 34'sd255;
            5'd23:   v = 34'sd127;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/rotation_matrix_builder.sv]
// ============================================================================
// rotation_matrix_builder: Euler angle / quaternion to 3x3 rotation matrix
// Pipelined CORDIC sine/cosine, product stages and Q1.14 rounding/saturation.
// ============================================================================
// Throughput: one item per cycle; one CORDIC stage per iteration, then four
// product/sum/round stages. The whole pipeline holds while the output stalls.
// Reset: synchronous active low, clears all stage valid bits.
module rotation_matrix_builder #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rmb_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rmb_pkg::t_out_item  o_out_item
);
    import rmb_pkg::*;

    localparam int NS = (CORDIC_STEPS < AtanEntries) ? CORDIC_STEPS : AtanEntries;

    function automatic logic signed [33:0] mulq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        p = p + (64'sd1 <<< 29);
        return 34'(p >>> 30);
    endfunction

    function automatic logic signed [15:0] sat(input logic signed [33:0] v);
        logic signed [15:0] o;
        if (v > 34'(OneQ14))       o = 16'(OneQ14);
        else if (v < -34'(OneQ14)) o = -16'(OneQ14);
        else                       o = 16'(v);
        return o;
    endfunction

    logic en;
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // CORDIC stages; index 0 is the folded angle
    logic signed [33:0] r_cx [0:NS][0:2];
    logic signed [33:0] r_cy [0:NS][0:2];
    logic signed [33:0] r_cz [0:NS][0:2];
    logic        [2:0]  r_cf [0:NS];
    t_in_item           r_ci [0:NS];
    logic        [NS:0] r_cv;

    logic signed [15:0] ang [0:2];
    assign ang[0] = i_in_item.roll;
    assign ang[1] = i_in_item.pitch;
    assign ang[2] = i_in_item.yaw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else if (en) begin
            r_cv[0] <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [33:0] z;
        if (en) begin
            r_ci[0] <= i_in_item;
            for (int a = 0; a < 3; a++) begin
                z = {ang[a][15], ang[a], 17'b0};
                r_cx[0][a] <= CordicGain;
                r_cy[0][a] <= '0;
                if (z > HalfPiQ30) begin
                    r_cz[0][a] <= z - PiQ30;
                    r_cf[0][a] <= 1'b1;
                end else if (z < -HalfPiQ30) begin
                    r_cz[0][a] <= z + PiQ30;
                    r_cf[0][a] <= 1'b1;
                end else begin
                    r_cz[0][a] <= z;
                    r_cf[0][a] <= 1'b0;
                end
            end
        end
    end

    for (genvar g = 0; g < NS; g++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[g+1] <= 1'b0;
            end else if (en) begin
                r_cv[g+1] <= r_cv[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ci[g+1] <= r_ci[g];
                r_cf[g+1] <= r_cf[g];
                for (int a = 0; a < 3; a++) begin
                    if (!r_cz[g][a][33]) begin
                        r_cx[g+1][a] <= r_cx[g][a] - (r_cy[g][a] >>> g);
                        r_cy[g+1][a] <= r_cy[g][a] + (r_cx[g][a] >>> g);
                        r_cz[g+1][a] <= r_cz[g][a] - atan_q30(5'(g));
                    end else begin
                        r_cx[g+1][a] <= r_cx[g][a] + (r_cy[g][a] >>> g);
                        r_cy[g+1][a] <= r_cy[g][a] - (r_cx[g][a] >>> g);
                        r_cz[g+1][a] <= r_cz[g][a] + atan_q30(5'(g));
                    end
                end
            end
        end
    end

    // stage A: sin/cos, quaternion products
    logic signed [31:0] r_s [0:2];
    logic signed [31:0] r_c [0:2];
    logic signed [31:0] r_xx, r_yy, r_zz, r_ww, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    logic               r_av, r_aop;

    // stage B: first Euler products, quaternion sums
    logic signed [33:0] r_spcy, r_spsy, r_cpcy, r_crsy, r_srsy, r_cpsy;
    logic signed [33:0] r_crcy, r_srcy, r_srcp, r_crcp;
    logic signed [31:0] r_bsr, r_bcr, r_bsp;
    logic signed [33:0] r_bq [0:8];
    logic               r_bv, r_bop;

    // stage C: Euler entries in Q.30, quaternion entries in Q.28
    logic signed [33:0] r_me [0:8];
    logic signed [33:0] r_mq [0:8];
    logic               r_mv, r_mop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av        <= 1'b0;
            r_bv        <= 1'b0;
            r_mv        <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (en) begin
            r_av        <= r_cv[NS];
            r_bv        <= r_av;
            r_mv        <= r_bv;
            o_out_valid <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [33:0] rq [0:8];
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                r_s[a] <= r_cf[NS][a] ? 32'(-r_cy[NS][a]) : 32'(r_cy[NS][a]);
                r_c[a] <= r_cf[NS][a] ? 32'(-r_cx[NS][a]) : 32'(r_cx[NS][a]);
            end
            r_aop <= r_ci[NS].opcode;
            r_xx  <= r_ci[NS].quat_x * r_ci[NS].quat_x;
            r_yy  <= r_ci[NS].quat_y * r_ci[NS].quat_y;
            r_zz  <= r_ci[NS].quat_z * r_ci[NS].quat_z;
            r_ww  <= r_ci[NS].quat_w * r_ci[NS].quat_w;
            r_xy  <= r_ci[NS].quat_x * r_ci[NS].quat_y;
            r_xz  <= r_ci[NS].quat_x * r_ci[NS].quat_z;
            r_yz  <= r_ci[NS].quat_y * r_ci[NS].quat_z;
            r_wx  <= r_ci[NS].quat_w * r_ci[NS].quat_x;
            r_wy  <= r_ci[NS].quat_w * r_ci[NS].quat_y;
            r_wz  <= r_ci[NS].quat_w * r_ci[NS].quat_z;

            r_bop  <= r_aop;
            r_bsr  <= r_s[0];
            r_bcr  <= r_c[0];
            r_bsp  <= r_s[1];
            r_spcy <= mulq(r_s[1], r_c[2]);
            r_spsy <= mulq(r_s[1], r_s[2]);
            r_cpcy <= mulq(r_c[1], r_c[2]);
            r_crsy <= mulq(r_c[0], r_s[2]);
            r_srsy <= mulq(r_s[0], r_s[2]);
            r_cpsy <= mulq(r_c[1], r_s[2]);
            r_crcy <= mulq(r_c[0], r_c[2]);
            r_srcy <= mulq(r_s[0], r_c[2]);
            r_srcp <= mulq(r_s[0], r_c[1]);
            r_crcp <= mulq(r_c[0], r_c[1]);
            r_bq[0] <= 34'(r_ww) + 34'(r_xx) - 34'(r_yy) - 34'(r_zz);
            r_bq[1] <= (34'(r_xy) - 34'(r_wz)) <<< 1;
            r_bq[2] <= (34'(r_xz) + 34'(r_wy)) <<< 1;
            r_bq[3] <= (34'(r_xy) + 34'(r_wz)) <<< 1;
            r_bq[4] <= 34'(r_ww) - 34'(r_xx) + 34'(r_yy) - 34'(r_zz);
            r_bq[5] <= (34'(r_yz) - 34'(r_wx)) <<< 1;
            r_bq[6] <= (34'(r_xz) - 34'(r_wy)) <<< 1;
            r_bq[7] <= (34'(r_yz) + 34'(r_wx)) <<< 1;
            r_bq[8] <= 34'(r_ww) - 34'(r_xx) - 34'(r_yy) + 34'(r_zz);

            r_mop   <= r_bop;
            r_mq    <= r_bq;
            r_me[0] <= r_cpcy;
            r_me[1] <= mulq(r_bsr, 32'(r_spcy)) - r_crsy;
            r_me[2] <= mulq(r_bcr, 32'(r_spcy)) + r_srsy;
            r_me[3] <= r_cpsy;
            r_me[4] <= mulq(r_bsr, 32'(r_spsy)) + r_crcy;
            r_me[5] <= mulq(r_bcr, 32'(r_spsy)) - r_srcy;
            r_me[6] <= -34'(r_bsp);
            r_me[7] <= r_srcp;
            r_me[8] <= r_crcp;

            for (int k = 0; k < 9; k++) begin
                if (r_mop == OpQuat) begin
                    rq[k] = (r_mq[k] + (34'sd1 <<< 13)) >>> 14;
                end else begin
                    rq[k] = (r_me[k] + (34'sd1 <<< 15)) >>> 16;
                end
            end
            o_out_item.r00 <= sat(rq[0]);
            o_out_item.r01 <= sat(rq[1]);
            o_out_item.r02 <= sat(rq[2]);
            o_out_item.r10 <= sat(rq[3]);
            o_out_item.r11 <= sat(rq[4]);
            o_out_item.r12 <= sat(rq[5]);
            o_out_item.r20 <= sat(rq[6]);
            o_out_item.r21 <= sat(rq[7]);
            o_out_item.r22 <= sat(rq[8]);
        end
    end

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !r_mv && !r_bv && !r_av)
        else $error("pipeline valid not cleared by reset");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |=> $stable(r_mv) && $stable(r_bv) && $stable(r_cv))
        else $error("pipeline moved while output stalled");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.r00 <= 16'sd16384 && o_out_item.r00 >= -16'sd16384
            && o_out_item.r22 <= 16'sd16384 && o_out_item.r22 >= -16'sd16384)
        else $error("output entry outside saturation range");

endmodule
